/* sv/msp_pkg.sv */
package msp_pkg;

   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_M      = 8'h4D;
   localparam logic [7:0] CHAR_ARROW  = 8'h3E;

   localparam int LEN_W   = 7;
   localparam int INDEX_W = 6;
   localparam int BYTE_W  = 8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DOLLAR,
      ST_M,
      ST_ARROW,
      ST_CMD,
      ST_PAYLOAD,
      ST_EMIT
   } msp_state_type;

   typedef struct packed {
      logic load_len;
      logic load_cmd;
      logic store_byte;
      logic emit_load;
   } msp_cmd_type;

   typedef struct packed {
      logic is_dollar;
      logic is_m;
      logic is_arrow;
      logic len_ok;
      logic count_done;
      logic xor_match;
      logic emit_last;
      logic out_free;
   } msp_status_type;

endpackage

/* sv/msp_ctrl.sv */
module msp_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  msp_pkg::msp_status_type sts,
   output msp_pkg::msp_cmd_type    cmd
);

   msp_pkg::msp_state_type state_ff;
   msp_pkg::msp_state_type state_in;
   logic                   accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= msp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      req_ready      = (state_ff != msp_pkg::ST_EMIT);
      accept         = req_valid && req_ready;
      case (state_ff)
         msp_pkg::ST_IDLE: begin
            if (accept && sts.is_dollar) state_in = msp_pkg::ST_DOLLAR;
         end
         msp_pkg::ST_DOLLAR: begin
            if (accept) state_in = sts.is_m ? msp_pkg::ST_M : msp_pkg::ST_IDLE;
         end
         msp_pkg::ST_M: begin
            if (accept) state_in = sts.is_arrow ? msp_pkg::ST_ARROW : msp_pkg::ST_IDLE;
         end
         msp_pkg::ST_ARROW: begin
            if (accept) begin
               if (sts.len_ok) begin
                  cmd.load_len = 1'b1;
                  state_in     = msp_pkg::ST_CMD;
               end else begin
                  state_in = msp_pkg::ST_IDLE;
               end
            end
         end
         msp_pkg::ST_CMD: begin
            if (accept) begin
               cmd.load_cmd = 1'b1;
               state_in     = msp_pkg::ST_PAYLOAD;
            end
         end
         msp_pkg::ST_PAYLOAD: begin
            if (accept) begin
               if (!sts.count_done) begin
                  cmd.store_byte = 1'b1;
               end else begin
                  // checksum word: emit on match, drop otherwise
                  state_in = sts.xor_match ? msp_pkg::ST_EMIT : msp_pkg::ST_IDLE;
               end
            end
         end
         msp_pkg::ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit_load = 1'b1;
               if (sts.emit_last) state_in = msp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = msp_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

/* sv/msp_dpath.sv */
module msp_dpath #(
   parameter int MAX_PAYLOAD = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [7:0]              req_rx_byte,
   input  msp_pkg::msp_cmd_type    cmd,
   output msp_pkg::msp_status_type sts,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [7:0]              rsp_frame_command,
   output logic [6:0]              rsp_frame_length,
   output logic                    rsp_has_payload,
   output logic [5:0]              rsp_payload_index,
   output logic [7:0]              rsp_payload_byte,
   output logic                    rsp_last
);

   localparam int IDX_W     = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int MEM_DEPTH = (MAX_PAYLOAD > 1) ? MAX_PAYLOAD : 2;

   logic [msp_pkg::BYTE_W-1:0] mem [MEM_DEPTH];

   logic [msp_pkg::LEN_W-1:0]  len_ff;
   logic [msp_pkg::LEN_W-1:0]  count_ff;
   logic [msp_pkg::LEN_W-1:0]  count_in;
   logic [msp_pkg::LEN_W-1:0]  emit_idx_ff;
   logic [msp_pkg::LEN_W-1:0]  emit_idx_in;
   logic [msp_pkg::LEN_W-1:0]  emit_idx_next;
   logic [msp_pkg::BYTE_W-1:0] xor_ff;
   logic [msp_pkg::BYTE_W-1:0] command_ff;
   logic [msp_pkg::BYTE_W-1:0] rd_data_ff;
   logic                       empty_frame;

   logic                        out_valid_ff;
   logic [msp_pkg::BYTE_W-1:0]  out_command_ff;
   logic [msp_pkg::LEN_W-1:0]   out_length_ff;
   logic                        out_has_payload_ff;
   logic [msp_pkg::INDEX_W-1:0] out_index_ff;
   logic [msp_pkg::BYTE_W-1:0]  out_byte_ff;
   logic                        out_last_ff;

   assign empty_frame   = (len_ff == '0);
   assign emit_idx_next = emit_idx_ff + 7'd1;
   assign count_in      = count_ff + 7'd1;

   always_comb begin
      emit_idx_in = emit_idx_ff;
      if (cmd.load_len) begin
         emit_idx_in = '0;
      end else if (cmd.emit_load) begin
         emit_idx_in = emit_idx_next;
      end
   end

   always_comb begin
      sts.is_dollar  = (req_rx_byte == msp_pkg::CHAR_DOLLAR);
      sts.is_m       = (req_rx_byte == msp_pkg::CHAR_M);
      sts.is_arrow   = (req_rx_byte == msp_pkg::CHAR_ARROW);
      sts.len_ok     = (req_rx_byte <= 8'(MAX_PAYLOAD));
      sts.count_done = (count_ff == len_ff);
      sts.xor_match  = (xor_ff == req_rx_byte);
      sts.emit_last  = empty_frame || (emit_idx_next == len_ff);
      sts.out_free   = !out_valid_ff || rsp_ready;
   end

   // payload store: write while parsing, read ahead of the emit index
   always_ff @(posedge clock) begin
      if (cmd.store_byte) begin
         mem[count_ff[IDX_W-1:0]] <= req_rx_byte;
      end
      rd_data_ff <= mem[emit_idx_in[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      emit_idx_ff <= emit_idx_in;
      if (cmd.load_len) begin
         len_ff   <= req_rx_byte[msp_pkg::LEN_W-1:0];
         xor_ff   <= req_rx_byte;
         count_ff <= '0;
      end
      if (cmd.load_cmd) begin
         command_ff <= req_rx_byte;
         xor_ff     <= xor_ff ^ req_rx_byte;
      end
      if (cmd.store_byte) begin
         xor_ff   <= xor_ff ^ req_rx_byte;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         out_command_ff     <= command_ff;
         out_length_ff      <= len_ff;
         out_has_payload_ff <= !empty_frame;
         out_index_ff       <= empty_frame ? '0 : emit_idx_ff[msp_pkg::INDEX_W-1:0];
         out_byte_ff        <= empty_frame ? '0 : rd_data_ff;
         out_last_ff        <= empty_frame || (emit_idx_next == len_ff);
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_frame_command = out_command_ff;
   assign rsp_frame_length  = out_length_ff;
   assign rsp_has_payload   = out_has_payload_ff;
   assign rsp_payload_index = out_index_ff;
   assign rsp_payload_byte  = out_byte_ff;
   assign rsp_last          = out_last_ff;

endmodule

/* sv/msp_response_frame_parser_top.sv */
// Input: one byte word per cycle while parsing; a checksum word that matches starts
// an emit burst during which req_ready stays low.
// Emit burst: one result per cycle from the payload store read port, one result per
// payload byte (a single result for an empty frame); it holds while rsp_ready is low.
// After the checksum word, the emit state loads the first result into the output register.
// Reset clears the parser state and the result valid; the payload store is not cleared.
module msp_response_frame_parser_top #(
   parameter int MAX_PAYLOAD = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_frame_command,
   output logic [6:0] rsp_frame_length,
   output logic       rsp_has_payload,
   output logic [5:0] rsp_payload_index,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_last
);

   msp_pkg::msp_cmd_type    cmd;
   msp_pkg::msp_status_type sts;

   msp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   msp_dpath #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_rx_byte       (req_rx_byte),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_frame_command (rsp_frame_command),
      .rsp_frame_length  (rsp_frame_length),
      .rsp_has_payload   (rsp_has_payload),
      .rsp_payload_index (rsp_payload_index),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_last          (rsp_last)
   );

   a_input_reopens: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_load && sts.emit_last) |=> req_ready)
      else $error("input not reopened after last result");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_has_payload) |->
         (rsp_last && rsp_payload_byte == 8'd0 && rsp_payload_index == 6'd0))
      else $error("empty-frame result malformed");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_has_payload) |-> ({1'b0, rsp_payload_index} < rsp_frame_length))
      else $error("payload index beyond frame length");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_load |-> !(cmd.store_byte || cmd.load_len || cmd.load_cmd))
      else $error("emit overlaps parsing");

endmodule

/* sim/tb_top.sv */
module tb_top;

   localparam int FRAME_MAX    = 64;
   localparam int WORD_TARGET  = 370;
   localparam int DRAIN_LIMIT  = 20000;
   localparam int SETTLE_TICKS = 16;

   typedef struct {
      logic [7:0] command;
      logic [6:0] length;
      logic       has_payload;
      logic [5:0] index;
      logic [7:0] data;
      logic       last;
   } rsp_word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_frame_command;
   logic [6:0] rsp_frame_length;
   logic       rsp_has_payload;
   logic [5:0] rsp_payload_index;
   logic [7:0] rsp_payload_byte;
   logic       rsp_last;

   // Parser mirror state
   msp_pkg::msp_state_type rx_phase = msp_pkg::ST_IDLE;
   logic [6:0]             want_len = '0;
   logic [6:0]             got_count = '0;
   logic [7:0]             csum = '0;
   logic [7:0]             cmd_held = '0;
   logic [7:0]             payload_mem [FRAME_MAX];

   rsp_word_type expected_rsp [$];
   int unsigned  failures = 0;
   int unsigned  words_sent = 0;
   int unsigned  hold_request = 0;
   int unsigned  stall_left = 0;
   bit           steady = 1'b0;

   msp_response_frame_parser_top #(
      .MAX_PAYLOAD(FRAME_MAX)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_frame_command(rsp_frame_command),
      .rsp_frame_length(rsp_frame_length),
      .rsp_has_payload(rsp_has_payload),
      .rsp_payload_index(rsp_payload_index),
      .rsp_payload_byte(rsp_payload_byte),
      .rsp_last(rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned idle_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (steady || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Advance the parser mirror by one accepted word and queue any frame results.
   task automatic parse_word(input logic [7:0] b);
      rsp_word_type w;
      case (rx_phase)
         msp_pkg::ST_IDLE: begin
            if (b == msp_pkg::CHAR_DOLLAR) rx_phase = msp_pkg::ST_DOLLAR;
         end
         msp_pkg::ST_DOLLAR: begin
            rx_phase = (b == msp_pkg::CHAR_M) ? msp_pkg::ST_M : msp_pkg::ST_IDLE;
         end
         msp_pkg::ST_M: begin
            rx_phase = (b == msp_pkg::CHAR_ARROW) ? msp_pkg::ST_ARROW : msp_pkg::ST_IDLE;
         end
         msp_pkg::ST_ARROW: begin
            if (b > FRAME_MAX) begin
               rx_phase = msp_pkg::ST_IDLE;
            end else begin
               want_len = b[6:0];
               csum = b;
               got_count = '0;
               rx_phase = msp_pkg::ST_CMD;
            end
         end
         msp_pkg::ST_CMD: begin
            cmd_held = b;
            csum ^= b;
            rx_phase = msp_pkg::ST_PAYLOAD;
         end
         msp_pkg::ST_PAYLOAD: begin
            if (got_count < want_len) begin
               csum ^= b;
               payload_mem[got_count[5:0]] = b;
               got_count++;
            end else begin
               if (csum == b) begin
                  if (want_len == 0) begin
                     w = '{cmd_held, 7'd0, 1'b0, 6'd0, 8'h00, 1'b1};
                     expected_rsp.push_back(w);
                  end
                  for (int i = 0; i < want_len; i++) begin
                     w = '{cmd_held, want_len, 1'b1, 6'(i), payload_mem[i],
                           (i + 1 == want_len)};
                     expected_rsp.push_back(w);
                  end
               end
               rx_phase = msp_pkg::ST_IDLE;
            end
         end
         default: rx_phase = msp_pkg::ST_IDLE;
      endcase
   endtask

   task automatic send_word(input logic [7:0] b);
      int unsigned gap;
      gap = idle_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      parse_word(b);
      words_sent++;
   endtask

   task automatic send_header(input logic [7:0] len);
      send_word(msp_pkg::CHAR_DOLLAR);
      send_word(msp_pkg::CHAR_M);
      send_word(msp_pkg::CHAR_ARROW);
      send_word(len);
   endtask

   task automatic send_frame(input logic [7:0] cmd, input int len, input bit bad_sum,
                             input bit use_fill = 1'b0, input logic [7:0] fill = 8'h00);
      logic [7:0] sum;
      logic [7:0] data;
      sum = 8'(len) ^ cmd;
      send_header(8'(len));
      send_word(cmd);
      for (int i = 0; i < len; i++) begin
         data = use_fill ? fill : 8'($urandom);
         sum ^= data;
         send_word(data);
      end
      if (bad_sum) sum ^= 8'($urandom_range(1, 255));
      send_word(sum);
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         failures++;
      end
   endtask

   // Result side: random stalls, or a long hold-off when requested.
   always @(posedge clock) begin
      if (hold_request != 0) begin
         stall_left = hold_request;
         hold_request = 0;
      end
      if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if (steady || $urandom_range(0, 3) != 0) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= 1'b0;
         stall_left = idle_gap();
      end
   end

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            $error("unexpected result word: command %0h index %0h byte %0h",
                   rsp_frame_command, rsp_payload_index, rsp_payload_byte);
            failures++;
         end else begin
            want = expected_rsp.pop_front();
            check_field("frame_command", want.command, rsp_frame_command);
            check_field("frame_length", want.length, rsp_frame_length);
            check_field("has_payload", want.has_payload, rsp_has_payload);
            check_field("payload_index", want.index, rsp_payload_index);
            check_field("payload_byte", want.data, rsp_payload_byte);
            check_field("last", want.last, rsp_last);
         end
      end
   end

   task automatic test_directed_cases();
      send_frame(8'h00, 0, 1'b0);
      send_frame(8'hFF, 1, 1'b0, 1'b1, 8'hFF);
      send_frame(8'h5A, 0, 1'b1);
      // oversized length drops back to idle
      send_header(8'd65);
      // header mismatches; the stray byte is not taken as a new start
      send_word(msp_pkg::CHAR_DOLLAR);
      send_word(8'h58);
      send_word(msp_pkg::CHAR_DOLLAR);
      send_word(msp_pkg::CHAR_M);
      send_word(8'h3C);
      send_word(msp_pkg::CHAR_DOLLAR);
      send_word(msp_pkg::CHAR_DOLLAR);
   endtask

   task automatic test_output_stall();
      hold_request = 400;
      for (int i = 0; i < 4; i++) send_frame(8'($urandom), $urandom_range(1, 6), 1'b0);
   endtask

   task automatic test_random_stream();
      int unsigned iter;
      int unsigned pick;
      int          len;
      iter = 0;
      while (words_sent < WORD_TARGET) begin
         steady = ((iter / 8) % 4 == 3);
         pick = $urandom_range(0, 99);
         len = $urandom_range(0, 99) < 75 ? $urandom_range(0, 8) : $urandom_range(0, FRAME_MAX);
         if (iter < 2 || $urandom_range(0, 19) == 0) len = FRAME_MAX;
         if (pick < 72) begin
            send_frame(8'($urandom), len, 1'b0);
         end else if (pick < 82) begin
            send_frame(8'($urandom), len, 1'b1);
         end else if (pick < 87) begin
            send_header(8'($urandom_range(FRAME_MAX + 1, 255)));
         end else if (pick < 93) begin
            send_word(msp_pkg::CHAR_DOLLAR);
            if ($urandom_range(0, 1)) send_word(msp_pkg::CHAR_M);
            send_word(8'($urandom));
         end else if (pick < 96) begin
            // cut a frame short; the following words land in its payload
            send_header(8'($urandom_range(2, 8)));
            send_word(8'($urandom));
            send_word(8'($urandom));
         end else begin
            repeat ($urandom_range(1, 4)) send_word(8'($urandom));
         end
         iter++;
      end
      steady = 1'b0;
   endtask

   initial begin
      int unsigned ticks;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_output_stall();
      test_random_stream();
      req_valid <= 1'b0;
      ticks = 0;
      while (expected_rsp.size() != 0 && ticks < DRAIN_LIMIT) begin
         @(posedge clock);
         ticks++;
      end
      repeat (SETTLE_TICKS) @(posedge clock);
      if (expected_rsp.size() != 0) begin
         $error("%0d expected result words never arrived", expected_rsp.size());
         failures++;
      end
      if (failures == 0) begin
         $display("** msp_response_frame_parser_top: PASSED **");
      end else begin
         $display("** msp_response_frame_parser_top: FAILED **");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("** msp_response_frame_parser_top: FAILED **");
      $finish;
   end

endmodule

/* files.f */
sv/msp_pkg.sv
sv/msp_ctrl.sv
sv/msp_dpath.sv
sv/msp_response_frame_parser_top.sv
sim/tb_top.sv
